/* hdl/tkz_pkg.sv */
// ----------------------------------------------------------------------------
// tkz_pkg - shared types and constants of the map text tokenizer
// Character codes, token kinds and the one-hot lexer mode encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tkz_pkg;

  // token kinds as seen on the result channel
  localparam logic [2:0] KIND_SYNTAX  = 3'd0;
  localparam logic [2:0] KIND_STRING  = 3'd1;
  localparam logic [2:0] KIND_NUMBER  = 3'd2;
  localparam logic [2:0] KIND_COMMENT = 3'd3;
  localparam logic [2:0] KIND_WORD    = 3'd4;

  // character codes
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_DIGIT_LO  = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI  = 8'h39;

  // lexer mode, one-hot
  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_STRING  = 7'b0000010,
    MODE_ESC     = 7'b0000100,
    MODE_NUMBER  = 7'b0001000,
    MODE_SLASH   = 7'b0010000,
    MODE_COMMENT = 7'b0100000,
    MODE_WORD    = 7'b1000000
  } lex_mode_t;

  // per-transfer emit summary from the lexer to the result queue
  typedef struct packed {
    logic [1:0] count;  // 0, 1 or 2 tokens produced by the accepted byte
  } emit_ctl_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB);
  endfunction

  function automatic logic is_syntax(input logic [7:0] b);
    return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LPAREN) ||
           (b == CH_RPAREN) || (b == CH_NEWLINE);
  endfunction

  function automatic logic is_numeric(input logic [7:0] b);
    return ((b >= CH_DIGIT_LO) && (b <= CH_DIGIT_HI)) || (b == CH_DOT) ||
           (b == CH_MINUS);
  endfunction

endpackage

`default_nettype wire

/* hdl/tkz_in_if.sv */
// ----------------------------------------------------------------------------
// tkz_in_if - text byte stream channel
// Valid/ready channel carrying one text byte and its end-of-text marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tkz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

/* hdl/tkz_out_if.sv */
// ----------------------------------------------------------------------------
// tkz_out_if - token result channel
// Valid/ready channel carrying one token descriptor per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tkz_out_if #(
  parameter int OFFSET_BITS = 24,
  parameter int LENGTH_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             token_kind;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [LENGTH_BITS-1:0] token_length;
  logic                   unterminated;
  logic                   last_of_run;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output unterminated, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input token_length, input unterminated, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

/* hdl/tkz_lex.sv */
// ----------------------------------------------------------------------------
// tkz_lex - lexer state and single-byte step
// Holds the open token state and computes up to two tokens per byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkz_lex #(
  parameter int OFFSET_BITS = 24,
  parameter int LENGTH_BITS = 16,
  localparam int RES_W = 3 + OFFSET_BITS + LENGTH_BITS + 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       text_byte,
  input  wire logic             end_of_text,
  output tkz_pkg::emit_ctl_t    emit_ctl,
  output logic [RES_W-1:0]      res0,
  output logic [RES_W-1:0]      res1
);

  tkz_pkg::lex_mode_t     mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;

  // candidate tokens: closed by this byte, syntax byte, flushed at end of text
  logic [RES_W-1:0] cand_close, cand_syn, cand_eot;
  logic             close_v, syn_v, eot_v;

  function automatic logic [LENGTH_BITS-1:0] bump(input logic [LENGTH_BITS-1:0] l);
    return (l == {LENGTH_BITS{1'b1}}) ? l : l + LENGTH_BITS'(1);
  endfunction

  function automatic logic [RES_W-1:0] pack_tok(input logic [2:0] kind,
                                                input logic [OFFSET_BITS-1:0] st,
                                                input logic [LENGTH_BITS-1:0] ln,
                                                input logic unterm);
    return {kind, st, ln, unterm, 1'b0};
  endfunction

  always_comb begin
    logic             taken;
    logic [2:0]       eot_kind;
    logic             eot_unterm;
    tkz_pkg::lex_mode_t m;
    taken      = 1'b0;
    m          = mode_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    close_v    = 1'b0;
    syn_v      = 1'b0;
    eot_v      = 1'b0;
    cand_close = '0;
    cand_syn   = '0;
    cand_eot   = '0;
    eot_kind   = tkz_pkg::KIND_WORD;
    eot_unterm = 1'b0;

    case (mode_r)
      tkz_pkg::MODE_STRING: begin
        len_nxt = bump(len_r);
        taken   = 1'b1;
        if (text_byte == tkz_pkg::CH_BACKSLASH) begin
          m = tkz_pkg::MODE_ESC;
        end else if (text_byte == tkz_pkg::CH_QUOTE) begin
          close_v    = 1'b1;
          cand_close = pack_tok(tkz_pkg::KIND_STRING, start_r, len_nxt, 1'b0);
          m          = tkz_pkg::MODE_IDLE;
        end
      end
      tkz_pkg::MODE_ESC: begin
        len_nxt = bump(len_r);
        taken   = 1'b1;
        m       = tkz_pkg::MODE_STRING;
      end
      tkz_pkg::MODE_NUMBER: begin
        if (tkz_pkg::is_numeric(text_byte)) begin
          len_nxt = bump(len_r);
          taken   = 1'b1;
        end else begin
          close_v    = 1'b1;
          cand_close = pack_tok(tkz_pkg::KIND_NUMBER, start_r, len_r, 1'b0);
          m          = tkz_pkg::MODE_IDLE;
        end
      end
      tkz_pkg::MODE_SLASH: begin
        if (text_byte == tkz_pkg::CH_SLASH) begin
          m       = tkz_pkg::MODE_COMMENT;
          len_nxt = bump(len_r);
          taken   = 1'b1;
        end else if (tkz_pkg::is_blank(text_byte) || text_byte == tkz_pkg::CH_NEWLINE) begin
          close_v    = 1'b1;
          cand_close = pack_tok(tkz_pkg::KIND_WORD, start_r, len_r, 1'b0);
          m          = tkz_pkg::MODE_IDLE;
        end else begin
          // lone slash turns into a bare word
          m       = tkz_pkg::MODE_WORD;
          len_nxt = bump(len_r);
          taken   = 1'b1;
        end
      end
      tkz_pkg::MODE_COMMENT: begin
        if (text_byte == tkz_pkg::CH_NEWLINE) begin
          close_v    = 1'b1;
          cand_close = pack_tok(tkz_pkg::KIND_COMMENT, start_r, len_r, 1'b0);
          m          = tkz_pkg::MODE_IDLE;
        end else begin
          len_nxt = bump(len_r);
          taken   = 1'b1;
        end
      end
      tkz_pkg::MODE_WORD: begin
        if (tkz_pkg::is_blank(text_byte) || text_byte == tkz_pkg::CH_NEWLINE) begin
          close_v    = 1'b1;
          cand_close = pack_tok(tkz_pkg::KIND_WORD, start_r, len_r, 1'b0);
          m          = tkz_pkg::MODE_IDLE;
        end else begin
          len_nxt = bump(len_r);
          taken   = 1'b1;
        end
      end
      default: begin
        m = tkz_pkg::MODE_IDLE;
      end
    endcase

    // byte not consumed by an open token: syntax token or start of a new one
    if (!taken && !tkz_pkg::is_blank(text_byte)) begin
      if (tkz_pkg::is_syntax(text_byte)) begin
        syn_v    = 1'b1;
        cand_syn = pack_tok(tkz_pkg::KIND_SYNTAX, offset_r, LENGTH_BITS'(1), 1'b0);
      end else begin
        start_nxt = offset_r;
        len_nxt   = LENGTH_BITS'(1);
        if (text_byte == tkz_pkg::CH_QUOTE) begin
          m = tkz_pkg::MODE_STRING;
        end else if (tkz_pkg::is_numeric(text_byte)) begin
          m = tkz_pkg::MODE_NUMBER;
        end else if (text_byte == tkz_pkg::CH_SLASH) begin
          m = tkz_pkg::MODE_SLASH;
        end else begin
          m = tkz_pkg::MODE_WORD;
        end
      end
    end

    if (end_of_text) begin
      if (m != tkz_pkg::MODE_IDLE) begin
        if (m == tkz_pkg::MODE_STRING || m == tkz_pkg::MODE_ESC) begin
          eot_kind   = tkz_pkg::KIND_STRING;
          eot_unterm = 1'b1;
        end else if (m == tkz_pkg::MODE_NUMBER) begin
          eot_kind = tkz_pkg::KIND_NUMBER;
        end else if (m == tkz_pkg::MODE_COMMENT) begin
          eot_kind = tkz_pkg::KIND_COMMENT;
        end
        eot_v    = 1'b1;
        cand_eot = pack_tok(eot_kind, start_nxt, len_nxt, eot_unterm);
      end
      m          = tkz_pkg::MODE_IDLE;
      start_nxt  = '0;
      len_nxt    = '0;
      offset_nxt = '0;
    end else begin
      offset_nxt = offset_r + OFFSET_BITS'(1);
    end
    mode_nxt = m;
  end

  // compact the (at most two) valid candidates in order
  always_comb begin
    logic [RES_W-1:0] r0, r1;
    r0 = close_v ? cand_close : (syn_v ? cand_syn : cand_eot);
    r1 = close_v ? (syn_v ? cand_syn : cand_eot) : cand_eot;
    emit_ctl.count = 2'(close_v) + 2'(syn_v) + 2'(eot_v);
    res0 = {r0[RES_W-1:1], emit_ctl.count == 2'd1};
    res1 = {r1[RES_W-1:1], 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= tkz_pkg::MODE_IDLE;
      start_r  <= '0;
      len_r    <= '0;
      offset_r <= '0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/tkz_outq.sv */
// ----------------------------------------------------------------------------
// tkz_outq - token result queue
// Four-entry queue taking up to two tokens per cycle, draining one when ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkz_outq #(
  parameter int RES_W = 45
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire tkz_pkg::emit_ctl_t emit_ctl,
  input  wire logic [RES_W-1:0]   res0,
  input  wire logic [RES_W-1:0]   res1,
  output logic                    room2,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output logic [RES_W-1:0]        q_data
);

  logic [RES_W-1:0] entry_r [4];
  logic [1:0]       wp_r, wp_nxt;
  logic [1:0]       rp_r, rp_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [1:0]       n_in;
  logic             pop;

  assign n_in    = push ? emit_ctl.count : 2'd0;
  assign q_valid = (cnt_r != 3'd0);
  assign pop     = q_valid && q_ready;
  assign q_data  = entry_r[rp_r];
  // only registered state here: no path from the result ready to input ready
  assign room2   = (cnt_r <= 3'd2);

  always_comb begin
    wp_nxt  = wp_r + n_in;
    rp_nxt  = rp_r + 2'(pop);
    cnt_nxt = cnt_r + 3'(n_in) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      entry_r[wp_r] <= res0;
    end
    if (n_in == 2'd2) begin
      entry_r[wp_r + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/map_text_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// map_text_tokenizer_core - streaming tokenizer for map text
// Splits a byte stream into syntax, string, number, comment and word tokens.
// ----------------------------------------------------------------------------
// Usage:
//   in_stream takes one text byte per transfer; end_of_text marks the last
//   byte of a text, after which offsets restart from zero.
//   out_stream gives one token per transfer: kind, start offset, length,
//   the unterminated-string flag and last_of_run, set on the final token
//   caused by a given input byte. A byte causes zero, one or two tokens.
//   A token is registered into the result queue when the byte that closes
//   it is transferred. Throughput: one byte per cycle, limited only by the
//   output side draining one token per cycle (a byte causing two tokens
//   needs two output transfers).
//   The lexer step is one level of logic between the mode/length registers;
//   tokens go through a four-entry queue, and in_stream.ready drops while
//   fewer than two entries are free, so a stalled receiver backs up the
//   input and nothing is lost.
//   Reset (rst_n low, synchronous) empties the queue and returns the lexer
//   to idle with offset zero and no open token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module map_text_tokenizer_core #(
  parameter int OFFSET_BITS = 24,
  parameter int LENGTH_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  tkz_in_if.sink   in_stream,
  tkz_out_if.source out_stream
);

  localparam int RES_W = 3 + OFFSET_BITS + LENGTH_BITS + 2;

  tkz_pkg::emit_ctl_t emit_ctl;
  logic [RES_W-1:0]   res0, res1, q_data;
  logic               room2;
  logic               step;

  assign in_stream.ready = room2;
  assign step            = in_stream.valid && room2;

  tkz_lex #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_lex (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .text_byte   (in_stream.text_byte),
    .end_of_text (in_stream.end_of_text),
    .emit_ctl    (emit_ctl),
    .res0        (res0),
    .res1        (res1)
  );

  tkz_outq #(
    .RES_W (RES_W)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (step),
    .emit_ctl (emit_ctl),
    .res0     (res0),
    .res1     (res1),
    .room2    (room2),
    .q_valid  (out_stream.valid),
    .q_ready  (out_stream.ready),
    .q_data   (q_data)
  );

  assign out_stream.token_kind   = q_data[RES_W-1 -: 3];
  assign out_stream.start_offset = q_data[LENGTH_BITS+2 +: OFFSET_BITS];
  assign out_stream.token_length = q_data[2 +: LENGTH_BITS];
  assign out_stream.unterminated = q_data[1];
  assign out_stream.last_of_run  = q_data[0];

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench - self-checking bench for map_text_tokenizer_core
// A directed walk over the token kinds and the corner cases (escapes, a lone
// slash, an end of text inside a token) is followed by random texts built
// from token-shaped fragments plus noise. A scoreboard model of the lexer
// predicts unpinned tokens, and each token transfer is compared field by field.
// Sender and receiver gaps vary over three phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int OFFSET_BITS = 24;
  localparam int LENGTH_BITS = 16;
  localparam int HOLD_CYCLES = 90;

  typedef struct packed {
    logic [2:0]             kind;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic                   unterm;
    logic                   last;
  } token_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       pin;
    token_t     tok;
  } plan_row_t;

  typedef enum int {
    SH_SYNTAX, SH_BLANK, SH_NUMBER, SH_STRING, SH_COMMENT, SH_WORD, SH_SLASH,
    SH_NOISE
  } shape_t;

  logic clk;
  logic rst_n;

  tkz_in_if in_ch ();
  tkz_out_if #(.OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS)) out_ch ();

  map_text_tokenizer_core #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_ch),
    .out_stream(out_ch)
  );

  // lexer model state
  tkz_pkg::lex_mode_t     lx_mode;
  logic [OFFSET_BITS-1:0] lx_start;
  logic [LENGTH_BITS-1:0] lx_len;
  logic [OFFSET_BITS-1:0] lx_pos;
  token_t                 scan_out [0:1];
  int                     scan_n;

  token_t    token_q [$];
  plan_row_t plan [$];
  int        errors = 0;
  int        items_sent = 0;
  int        send_idle = 0;
  int        recv_idle = 0;
  int        hold_left = 0;
  bit        hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- model
  function automatic logic ch_blank(input logic [7:0] c);
    case (c)
      tkz_pkg::CH_SPACE, tkz_pkg::CH_TAB: return 1'b1;
      default:                            return 1'b0;
    endcase
  endfunction

  function automatic logic ch_punct(input logic [7:0] c);
    case (c)
      tkz_pkg::CH_LBRACE, tkz_pkg::CH_RBRACE, tkz_pkg::CH_LPAREN,
      tkz_pkg::CH_RPAREN, tkz_pkg::CH_NEWLINE: return 1'b1;
      default:                                 return 1'b0;
    endcase
  endfunction

  function automatic logic ch_numeric(input logic [7:0] c);
    if (c == tkz_pkg::CH_DOT || c == tkz_pkg::CH_MINUS) return 1'b1;
    return c >= tkz_pkg::CH_DIGIT_LO && c <= tkz_pkg::CH_DIGIT_HI;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic void note_token(input logic [2:0] kind,
                                     input logic [OFFSET_BITS-1:0] start,
                                     input logic [LENGTH_BITS-1:0] len,
                                     input logic unterm);
    scan_out[scan_n] = '{kind: kind, start: start, len: len, unterm: unterm,
                         last: 1'b0};
    scan_n++;
  endfunction

  function automatic void lexer_reset();
    lx_mode  = tkz_pkg::MODE_IDLE;
    lx_start = '0;
    lx_len   = '0;
    lx_pos   = '0;
  endfunction

  // advances the lexer by one byte; tokens land in scan_out[0:scan_n-1]
  function automatic void scan_byte(input logic [7:0] b, input logic eot);
    logic [OFFSET_BITS-1:0] off;
    logic                   taken;
    logic [2:0]             kind;
    off    = lx_pos;
    taken  = 1'b0;
    scan_n = 0;
    case (lx_mode)
      tkz_pkg::MODE_STRING: begin
        lx_len = len_inc(lx_len);
        taken  = 1'b1;
        if (b == tkz_pkg::CH_BACKSLASH) begin
          lx_mode = tkz_pkg::MODE_ESC;
        end else if (b == tkz_pkg::CH_QUOTE) begin
          note_token(tkz_pkg::KIND_STRING, lx_start, lx_len, 1'b0);
          lx_mode = tkz_pkg::MODE_IDLE;
        end
      end
      tkz_pkg::MODE_ESC: begin
        lx_len  = len_inc(lx_len);
        lx_mode = tkz_pkg::MODE_STRING;
        taken   = 1'b1;
      end
      tkz_pkg::MODE_NUMBER: begin
        if (ch_numeric(b)) begin
          lx_len = len_inc(lx_len);
          taken  = 1'b1;
        end else begin
          note_token(tkz_pkg::KIND_NUMBER, lx_start, lx_len, 1'b0);
          lx_mode = tkz_pkg::MODE_IDLE;
        end
      end
      tkz_pkg::MODE_SLASH: begin
        if (b == tkz_pkg::CH_SLASH) begin
          lx_mode = tkz_pkg::MODE_COMMENT;
          lx_len  = len_inc(lx_len);
          taken   = 1'b1;
        end else if (ch_blank(b) || b == tkz_pkg::CH_NEWLINE) begin
          note_token(tkz_pkg::KIND_WORD, lx_start, lx_len, 1'b0);
          lx_mode = tkz_pkg::MODE_IDLE;
        end else begin
          // lone slash: the next byte joins a word
          lx_mode = tkz_pkg::MODE_WORD;
          lx_len  = len_inc(lx_len);
          taken   = 1'b1;
        end
      end
      tkz_pkg::MODE_COMMENT: begin
        if (b == tkz_pkg::CH_NEWLINE) begin
          note_token(tkz_pkg::KIND_COMMENT, lx_start, lx_len, 1'b0);
          lx_mode = tkz_pkg::MODE_IDLE;
        end else begin
          lx_len = len_inc(lx_len);
          taken  = 1'b1;
        end
      end
      tkz_pkg::MODE_WORD: begin
        if (ch_blank(b) || b == tkz_pkg::CH_NEWLINE) begin
          note_token(tkz_pkg::KIND_WORD, lx_start, lx_len, 1'b0);
          lx_mode = tkz_pkg::MODE_IDLE;
        end else begin
          lx_len = len_inc(lx_len);
          taken  = 1'b1;
        end
      end
      default: lx_mode = tkz_pkg::MODE_IDLE;
    endcase

    if (!taken && !ch_blank(b)) begin
      if (ch_punct(b)) begin
        note_token(tkz_pkg::KIND_SYNTAX, off, LENGTH_BITS'(1), 1'b0);
      end else begin
        lx_start = off;
        lx_len   = LENGTH_BITS'(1);
        if (b == tkz_pkg::CH_QUOTE)      lx_mode = tkz_pkg::MODE_STRING;
        else if (ch_numeric(b))          lx_mode = tkz_pkg::MODE_NUMBER;
        else if (b == tkz_pkg::CH_SLASH) lx_mode = tkz_pkg::MODE_SLASH;
        else                             lx_mode = tkz_pkg::MODE_WORD;
      end
    end

    if (eot) begin
      // flush whatever is open, then restart offsets for the next text
      if (lx_mode != tkz_pkg::MODE_IDLE) begin
        case (lx_mode)
          tkz_pkg::MODE_STRING, tkz_pkg::MODE_ESC: kind = tkz_pkg::KIND_STRING;
          tkz_pkg::MODE_NUMBER:                    kind = tkz_pkg::KIND_NUMBER;
          tkz_pkg::MODE_COMMENT:                   kind = tkz_pkg::KIND_COMMENT;
          default:                                 kind = tkz_pkg::KIND_WORD;
        endcase
        note_token(kind, lx_start, lx_len,
                   lx_mode == tkz_pkg::MODE_STRING || lx_mode == tkz_pkg::MODE_ESC);
      end
      lexer_reset();
    end else begin
      lx_pos = off + OFFSET_BITS'(1);
    end

    if (scan_n > 0) scan_out[scan_n-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- sender
  task automatic push_byte(input logic [7:0] b, input logic eot, input logic pin,
                           input token_t pinned);
    int k;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    scan_byte(b, eot);
    if (pin) begin
      token_q.push_back(pinned);
    end else begin
      for (k = 0; k < scan_n; k++) token_q.push_back(scan_out[k]);
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(2))
      0:       return tkz_pkg::CH_SPACE;
      1:       return tkz_pkg::CH_TAB;
      default: return tkz_pkg::CH_NEWLINE;
    endcase
  endfunction

  // one random text: token-shaped fragments with random content, plus noise
  task automatic send_text();
    logic [7:0] text_q [$];
    logic [7:0] c;
    shape_t     sh;
    int         ntok, k, j, n;
    logic       tail;
    ntok = $urandom_range(1, 8);
    for (k = 0; k < ntok; k++) begin
      tail = (k == ntok - 1);
      if ($urandom_range(9) == 0) sh = SH_NOISE;
      else sh = shape_t'($urandom_range(0, 6));
      case (sh)
        SH_SYNTAX: begin
          case ($urandom_range(4))
            0: text_q.push_back(tkz_pkg::CH_LBRACE);
            1: text_q.push_back(tkz_pkg::CH_RBRACE);
            2: text_q.push_back(tkz_pkg::CH_LPAREN);
            3: text_q.push_back(tkz_pkg::CH_RPAREN);
            default: text_q.push_back(tkz_pkg::CH_NEWLINE);
          endcase
        end
        SH_BLANK: begin
          n = $urandom_range(1, 3);
          for (j = 0; j < n; j++)
            text_q.push_back($urandom_range(1) ? tkz_pkg::CH_SPACE : tkz_pkg::CH_TAB);
        end
        SH_NUMBER: begin
          n = $urandom_range(1, 6);
          for (j = 0; j < n; j++) begin
            c = 8'($urandom_range(0, 11));
            if (c < 10)       text_q.push_back(tkz_pkg::CH_DIGIT_LO + c);
            else if (c == 10) text_q.push_back(tkz_pkg::CH_DOT);
            else              text_q.push_back(tkz_pkg::CH_MINUS);
          end
        end
        SH_STRING: begin
          text_q.push_back(tkz_pkg::CH_QUOTE);
          n = $urandom_range(0, 10);
          for (j = 0; j < n; j++) begin
            if ($urandom_range(5) == 0) begin
              text_q.push_back(tkz_pkg::CH_BACKSLASH);
              // a trailing escape may be cut by the end of text
              if (!(tail && j == n - 1 && $urandom_range(1)))
                text_q.push_back(8'($urandom_range(1, 255)));
            end else begin
              c = 8'($urandom_range(1, 255));
              if (c == tkz_pkg::CH_QUOTE || c == tkz_pkg::CH_BACKSLASH) c = 8'h61;
              text_q.push_back(c);
            end
          end
          if (!(tail && $urandom_range(2) == 0)) text_q.push_back(tkz_pkg::CH_QUOTE);
        end
        SH_COMMENT: begin
          text_q.push_back(tkz_pkg::CH_SLASH);
          text_q.push_back(tkz_pkg::CH_SLASH);
          n = $urandom_range(0, 10);
          for (j = 0; j < n; j++) begin
            c = 8'($urandom_range(1, 255));
            text_q.push_back(c == tkz_pkg::CH_NEWLINE ? tkz_pkg::CH_SPACE : c);
          end
          if (!(tail && $urandom_range(2) == 0)) text_q.push_back(tkz_pkg::CH_NEWLINE);
        end
        SH_WORD: begin
          text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
          n = $urandom_range(0, 7);
          for (j = 0; j < n; j++) begin
            c = 8'($urandom_range(1, 255));
            if (ch_blank(c) || c == tkz_pkg::CH_NEWLINE) c = 8'h77;
            text_q.push_back(c);
          end
        end
        SH_SLASH: begin
          text_q.push_back(tkz_pkg::CH_SLASH);
          if ($urandom_range(1)) begin
            c = 8'($urandom_range(1, 255));
            text_q.push_back(c == tkz_pkg::CH_SLASH ? tkz_pkg::CH_LBRACE : c);
          end
        end
        default: begin
          n = $urandom_range(1, 4);
          for (j = 0; j < n; j++) text_q.push_back(8'($urandom_range(1, 255)));
        end
      endcase
      if (!tail && $urandom_range(1)) text_q.push_back(pick_sep());
    end
    for (k = 0; k < text_q.size(); k++)
      push_byte(text_q[k], k == text_q.size() - 1, 1'b0, '0);
  endtask

  task automatic run_random(input int upto);
    int texts;
    texts = 0;
    while (items_sent < upto) begin
      send_text();
      texts++;
      if (texts == 3) hold_req = 1'b1;
    end
  endtask

  task automatic add_row(input logic [7:0] ch, input logic eot, input logic pin,
                         input logic [2:0] kind, input int start, input int len,
                         input logic unterm);
    plan.push_back('{ch: ch, eot: eot, pin: pin,
                     tok: '{kind: kind, start: OFFSET_BITS'(start),
                            len: LENGTH_BITS'(len), unterm: unterm,
                            last: 1'b1}});
  endtask

  initial begin : stimulus
    int k;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = '0;
    in_ch.end_of_text = 1'b0;
    lexer_reset();

    //       byte                   eot   pin   kind                   start len unterm
    add_row(tkz_pkg::CH_LBRACE,    1'b0, 1'b1, tkz_pkg::KIND_SYNTAX,  0,    1,  1'b0);
    add_row(tkz_pkg::CH_QUOTE,     1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_BACKSLASH, 1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_QUOTE,     1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_QUOTE,     1'b0, 1'b1, tkz_pkg::KIND_STRING,  1,    4,  1'b0);
    add_row(tkz_pkg::CH_MINUS,     1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(8'h31,                 1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_DOT,       1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_RPAREN,    1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_SPACE,     1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_TAB,       1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_SLASH,     1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(8'h78,                 1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_NEWLINE,   1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_SLASH,     1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_SLASH,     1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(8'h63,                 1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_NEWLINE,   1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(8'hFF,                 1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(8'h01,                 1'b1, 1'b1, tkz_pkg::KIND_WORD,    18,   2,  1'b0);
    add_row(tkz_pkg::CH_QUOTE,     1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(8'h61,                 1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_BACKSLASH, 1'b1, 1'b1, tkz_pkg::KIND_STRING,  0,    3,  1'b1);
    add_row(tkz_pkg::CH_SLASH,     1'b1, 1'b1, tkz_pkg::KIND_WORD,    0,    1,  1'b0);
    add_row(tkz_pkg::CH_SLASH,     1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_SPACE,     1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(8'h37,                 1'b1, 1'b1, tkz_pkg::KIND_NUMBER,  2,    1,  1'b0);
    add_row(tkz_pkg::CH_LPAREN,    1'b0, 1'b0, tkz_pkg::KIND_SYNTAX,  0,    0,  1'b0);
    add_row(tkz_pkg::CH_RBRACE,    1'b1, 1'b1, tkz_pkg::KIND_SYNTAX,  1,    1,  1'b0);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle = 19;
    recv_idle = 65;
    for (k = 0; k < plan.size(); k++)
      push_byte(plan[k].ch, plan[k].eot, plan[k].pin, plan[k].tok);
    run_random(220);
    drain();

    send_idle = 65;
    recv_idle = 19;
    run_random(440);
    drain();

    send_idle = 0;
    recv_idle = 0;
    run_random(650);
    drain();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // -------------------------------------------------------------- receiver
  initial begin : ready_drive
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  function automatic void cmp_field(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  initial begin : token_check
    token_t exp_tok;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (token_q.size() == 0) begin
          $display("%0t: token transfer with none expected: kind %0d start %0d len %0d",
                   $time, out_ch.token_kind, out_ch.start_offset, out_ch.token_length);
          errors++;
        end else begin
          exp_tok = token_q.pop_front();
          cmp_field("token_kind", 32'(exp_tok.kind), 32'(out_ch.token_kind));
          cmp_field("start_offset", 32'(exp_tok.start), 32'(out_ch.start_offset));
          cmp_field("token_length", 32'(exp_tok.len), 32'(out_ch.token_length));
          cmp_field("unterminated", 32'(exp_tok.unterm), 32'(out_ch.unterminated));
          cmp_field("last_of_run", 32'(exp_tok.last), 32'(out_ch.last_of_run));
        end
      end
    end
  end

endmodule
